// ----- hdl/indexed_register_block_with_rtc_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the indexed register block with real-time clock.
// Every use expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef INDEXED_REGISTER_BLOCK_WITH_RTC_CORE_DEFINES_SVH
`define INDEXED_REGISTER_BLOCK_WITH_RTC_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IRBRTC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("irbrtc: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IRBRTC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("irbrtc: assertion failed");

`endif

// ----- hdl/irbrtc_pkg.sv -----
// ----------------------------------------------------------------------------
// irbrtc_pkg
// Shared types, opcodes and register indices of the indexed register block.
// ----------------------------------------------------------------------------
`default_nettype none

package irbrtc_pkg;

	localparam int DAY_BITS = 12;

	localparam int ADDR_W = 8;
	localparam int DATA_W = 8;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2
	} opcode_t;

	localparam logic PORT_INDEX = 1'b0;
	localparam logic PORT_DATA  = 1'b1;

	localparam logic [7:0] REG_JOY_GATE  = 8'h09;
	localparam logic [7:0] REG_JOYPAD    = 8'h0a;
	localparam logic [7:0] REG_TIMER_LO  = 8'h30;
	localparam logic [7:0] REG_TIMER_HI  = 8'h31;
	localparam logic [7:0] REG_SEC       = 8'h70;
	localparam logic [7:0] REG_MIN       = 8'h71;
	localparam logic [7:0] REG_HOUR      = 8'h72;
	localparam logic [7:0] REG_DAY_LO    = 8'h73;
	localparam logic [7:0] REG_DAY_HI    = 8'h74;
	localparam logic [7:0] REG_ALM_SEC   = 8'h75;
	localparam logic [7:0] REG_ALM_MIN   = 8'h76;
	localparam logic [7:0] REG_ALM_HOUR  = 8'h77;
	localparam logic [7:0] REG_ALM_DAY   = 8'h78;
	localparam logic [7:0] REG_IRQ_EN    = 8'h79;
	localparam logic [7:0] REG_IRQ_STAT  = 8'h7a;
	localparam logic [7:0] REG_WPROT     = 8'hc1;

	localparam logic [15:0] TIMER_RESET = 16'h7200;
	localparam logic [15:0] TIMER_STEP  = 16'h0100;

	// Commands from the bus side into the clock unit.
	typedef struct packed {
		logic       tick;
		logic       wr;
		logic [7:0] idx;
		logic [7:0] data;
	} rtc_cmd_t;

	// Clock unit status: current time, requests, and irq after this item.
	typedef struct packed {
		logic [5:0]          sec;
		logic [5:0]          min;
		logic [4:0]          hour;
		logic [DAY_BITS-1:0] day;
		logic [1:0]          req;
		logic                irq_nxt;
	} rtc_stat_t;

endpackage

`default_nettype wire

// ----- hdl/irbrtc_ram.sv -----
// ----------------------------------------------------------------------------
// irbrtc_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module irbrtc_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 8
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/irbrtc_rtc.sv -----
// ----------------------------------------------------------------------------
// irbrtc_rtc
// Time of day, day count, alarm, interrupt enables and request latches.
// ----------------------------------------------------------------------------
`default_nettype none

module irbrtc_rtc (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire irbrtc_pkg::rtc_cmd_t  cmd,
	output irbrtc_pkg::rtc_stat_t      stat
);

	import irbrtc_pkg::*;

	logic [5:0]          sec_q, sec_d;
	logic [5:0]          min_q, min_d;
	logic [4:0]          hour_q, hour_d;
	logic [DAY_BITS-1:0] day_q, day_d;
	logic [5:0]          alm_sec_q, alm_sec_d;
	logic [5:0]          alm_min_q, alm_min_d;
	logic [4:0]          alm_hour_q, alm_hour_d;
	logic [4:0]          alm_day_q, alm_day_d;
	logic [1:0]          ien_q, ien_d;
	logic [1:0]          req_q, req_d;

	logic [6:0]  sec_inc, min_inc;
	logic [5:0]  hour_inc;
	logic [15:0] day_ext, day_tmp;
	logic        alm_hit;

	always_comb begin
		sec_d      = sec_q;
		min_d      = min_q;
		hour_d     = hour_q;
		day_d      = day_q;
		alm_sec_d  = alm_sec_q;
		alm_min_d  = alm_min_q;
		alm_hour_d = alm_hour_q;
		alm_day_d  = alm_day_q;
		ien_d      = ien_q;
		req_d      = req_q;
		sec_inc    = {1'b0, sec_q} + 7'd1;
		min_inc    = {1'b0, min_q} + 7'd1;
		hour_inc   = {1'b0, hour_q} + 6'd1;
		day_ext    = 16'(day_q);
		day_tmp    = day_ext;
		alm_hit    = 1'b0;

		if (cmd.tick) begin
			// carry seconds into minutes, hours and days
			if (sec_inc >= 7'd60) begin
				sec_d = '0;
				if (min_inc >= 7'd60) begin
					min_d = '0;
					if (hour_inc >= 6'd24) begin
						hour_d = '0;
						day_d  = day_q + 1'b1;
					end else begin
						hour_d = hour_inc[4:0];
					end
				end else begin
					min_d = min_inc[5:0];
				end
			end else begin
				sec_d = sec_inc[5:0];
			end
			alm_hit = (sec_d == alm_sec_q) && (min_d == alm_min_q) &&
				(hour_d == alm_hour_q) && (day_d[4:0] == alm_day_q);
			req_d = {req_q[1] | alm_hit, 1'b1};
		end else if (cmd.wr) begin
			unique case (cmd.idx)
				REG_SEC:      sec_d = cmd.data[5:0];
				REG_MIN:      min_d = cmd.data[5:0];
				REG_HOUR:     hour_d = cmd.data[4:0];
				REG_DAY_LO: begin
					day_tmp = {day_ext[15:8], cmd.data};
					day_d   = day_tmp[DAY_BITS-1:0];
				end
				REG_DAY_HI: begin
					day_tmp = {cmd.data, day_ext[7:0]};
					day_d   = day_tmp[DAY_BITS-1:0];
				end
				REG_ALM_SEC:  alm_sec_d = cmd.data[5:0];
				REG_ALM_MIN:  alm_min_d = cmd.data[5:0];
				REG_ALM_HOUR: alm_hour_d = cmd.data[4:0];
				REG_ALM_DAY:  alm_day_d = cmd.data[4:0];
				REG_IRQ_EN:   ien_d = cmd.data[1:0];
				REG_IRQ_STAT: begin
					if (cmd.data[1]) begin
						req_d = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q      <= '0;
			min_q      <= '0;
			hour_q     <= '0;
			day_q      <= '0;
			alm_sec_q  <= '0;
			alm_min_q  <= '0;
			alm_hour_q <= '0;
			alm_day_q  <= '0;
			ien_q      <= '0;
			req_q      <= '0;
		end else if (en) begin
			sec_q      <= sec_d;
			min_q      <= min_d;
			hour_q     <= hour_d;
			day_q      <= day_d;
			alm_sec_q  <= alm_sec_d;
			alm_min_q  <= alm_min_d;
			alm_hour_q <= alm_hour_d;
			alm_day_q  <= alm_day_d;
			ien_q      <= ien_d;
			req_q      <= req_d;
		end
	end

	assign stat.sec     = sec_q;
	assign stat.min     = min_q;
	assign stat.hour    = hour_q;
	assign stat.day     = day_q;
	assign stat.req     = req_q;
	assign stat.irq_nxt = |(req_d & ien_d);

endmodule

`default_nettype wire

// ----- hdl/indexed_register_block_with_rtc_core.sv -----
// ----------------------------------------------------------------------------
// indexed_register_block_with_rtc_core
// Index/data bus port over a 256-byte register file, with real-time clock.
// ----------------------------------------------------------------------------
// Each item is a bus read, a bus write or a one-second tick and returns one
// result item (read_data, irq). The block takes one item per clock cycle as
// long as results are taken; a result passes through the synchronous
// register-file read and then the output register. All state changes at
// the accept edge, so a read that follows a write to the same index in
// the next cycle already sees the new byte. The register file is a 256x8
// RAM with one write and one read port; a per-entry valid bit, cleared at
// reset, makes unwritten entries read as zero, so no clearing pass runs
// after reset. The stand-in timer, clock, request status and write protect
// sit in flops beside the RAM and are merged into the read byte; the joypad
// index gives the gated input; joypad gate, alarm, enables read from RAM.
// irq shows the enabled pending requests as they stand after the item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_register_block_with_rtc_core_defines.svh"

module indexed_register_block_with_rtc_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic       port_select,
	input  wire logic [7:0] write_data,
	input  wire logic [7:0] joypad,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] read_data,
	output logic            irq
);

	import irbrtc_pkg::*;

	// bus-side state
	logic [7:0]  index_q;
	logic [15:0] timer_q;
	logic        wprot_q;
	logic        joy_gate_q;
	logic [255:0] vld_q;

	// read stage: RAM access in flight
	logic        s1_valid_q;
	logic [7:0]  keep_s1;
	logic [7:0]  alt_s1;
	logic        vld_s1;
	logic        irq_s1;

	// output register
	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic        irq_q;

	logic        accept, s1_adv;
	logic        is_read, is_write, is_tick, data_rd, data_wr;
	logic [15:0] timer_nxt;
	logic [15:0] day_ext;
	logic [7:0]  keep_c, alt_c;
	logic [7:0]  ram_rdata;

	rtc_cmd_t    rtc_cmd;
	rtc_stat_t   rtc_stat;

	// advance the read stage when the output register is free or being taken
	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign accept   = in_valid && in_ready;

	assign is_read  = (opcode == OP_READ);
	assign is_write = (opcode == OP_WRITE);
	assign is_tick  = (opcode == OP_TICK);
	assign data_rd  = is_read && (port_select == PORT_DATA);
	assign data_wr  = is_write && (port_select == PORT_DATA);

	// every read advances the stand-in timer before it is sampled
	assign timer_nxt = timer_q + TIMER_STEP;
	assign day_ext   = 16'(rtc_stat.day);

	assign rtc_cmd.tick = is_tick;
	assign rtc_cmd.wr   = data_wr;
	assign rtc_cmd.idx  = index_q;
	assign rtc_cmd.data = write_data;

	irbrtc_rtc u_rtc (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.cmd    (rtc_cmd),
		.stat   (rtc_stat)
	);

	irbrtc_ram #(
		.DATA_W (DATA_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (accept && data_wr),
		.waddr (index_q),
		.wdata (write_data),
		.re    (accept && data_rd),
		.raddr (index_q),
		.rdata (ram_rdata)
	);

	// Build the read byte as (stored & keep) | alt. Stored bytes pass whole
	// for plain indices, partly for the status and write-protect registers,
	// and not at all where the value lives outside the RAM.
	always_comb begin
		keep_c = '0;
		alt_c  = '0;
		if (is_read) begin
			if (port_select == PORT_INDEX) begin
				alt_c = index_q;
			end else begin
				unique case (index_q)
					REG_JOYPAD:   alt_c = joy_gate_q ? joypad : 8'hff;
					REG_TIMER_LO: alt_c = timer_nxt[7:0];
					REG_TIMER_HI: alt_c = timer_nxt[15:8];
					REG_SEC:      alt_c = {2'b00, rtc_stat.sec};
					REG_MIN:      alt_c = {2'b00, rtc_stat.min};
					REG_HOUR:     alt_c = {3'b000, rtc_stat.hour};
					REG_DAY_LO:   alt_c = day_ext[7:0];
					REG_DAY_HI:   alt_c = day_ext[15:8];
					REG_IRQ_STAT: begin
						keep_c = 8'hfc;
						alt_c  = {6'b0, rtc_stat.req};
					end
					REG_WPROT: begin
						keep_c = 8'hfe;
						alt_c  = {7'b0, wprot_q};
					end
					default:      keep_c = 8'hff;
				endcase
			end
		end
	end

	// bus-side state: update at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q    <= '0;
			timer_q    <= TIMER_RESET;
			wprot_q    <= 1'b1;
			joy_gate_q <= 1'b0;
			vld_q      <= '0;
		end else if (accept) begin
			if (is_read) begin
				timer_q <= timer_nxt;
			end
			if (data_rd && (index_q == REG_WPROT)) begin
				wprot_q <= 1'b0;
			end
			if (is_write && (port_select == PORT_INDEX)) begin
				index_q <= write_data;
			end
			if (data_wr) begin
				vld_q[index_q] <= 1'b1;
				if (index_q == REG_JOY_GATE) begin
					joy_gate_q <= write_data[0];
				end
			end
		end
	end

	// read stage: hold the merge controls while the RAM read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			keep_s1 <= keep_c;
			alt_s1  <= alt_c;
			vld_s1  <= vld_q[index_q];
			irq_s1  <= rtc_stat.irq_nxt;
		end
	end

	// output register: drop the result once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			read_data_q <= ((vld_s1 ? ram_rdata : 8'h00) & keep_s1) | alt_s1;
			irq_q       <= irq_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign irq       = irq_q;

	`IRBRTC_ASSERT_NOW(a_ready_when_out_free, !out_valid_q, in_ready)
	`IRBRTC_ASSERT_NEXT(a_s1_holds_on_stall, s1_valid_q && !s1_adv, s1_valid_q && $stable(alt_s1))
	`IRBRTC_ASSERT_NEXT(a_tick_sets_1hz, accept && is_tick, rtc_stat.req[0])

endmodule

`default_nettype wire

// ----- test/irbrtc_bus_checker.sv -----
// ----------------------------------------------------------------------------
// irbrtc_bus_checker
// Watches both item channels of the indexed register block, keeps its own
// copy of the register file, clock and request state, and compares every
// result item with the prediction for the oldest outstanding input item.
// ----------------------------------------------------------------------------
`default_nettype none

module irbrtc_bus_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] opcode,
	input  logic       port_select,
	input  logic [7:0] write_data,
	input  logic [7:0] joypad,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] read_data,
	input  logic       irq,
	output int         fail_count,
	output int         outstanding,
	output int         checked_count,
	output int         alarm_hits
);

	import irbrtc_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       irq;
	} bus_result_t;

	bus_result_t expected_results[$];
	bus_result_t oldest;

	logic [7:0]          index_q;
	logic [7:0]          regs [256];
	logic [15:0]         timer_q;
	logic [5:0]          sec_q;
	logic [5:0]          min_q;
	logic [4:0]          hour_q;
	logic [DAY_BITS-1:0] day_q;
	logic [5:0]          alm_sec;
	logic [5:0]          alm_min;
	logic [4:0]          alm_hour;
	logic [4:0]          alm_day;
	logic [1:0]          en_q;
	logic [1:0]          req_q;
	logic                wprot_q;

	int errors;
	int compared;
	int alarm_matches;

	// Update the shadow state for one item and return its result.
	function automatic bus_result_t apply_item(logic [1:0] op_bits, logic port,
			logic [7:0] wd, logic [7:0] joy);
		bus_result_t r;
		logic [31:0] wide;
		int s;
		int m;
		int h;
		r.data = 8'h00;
		wide = '0;
		wide[DAY_BITS-1:0] = day_q;
		case (opcode_t'(op_bits))
			OP_READ: begin
				timer_q = timer_q + TIMER_STEP;
				if (port == PORT_INDEX) begin
					r.data = index_q;
				end else begin
					r.data = regs[index_q];
					case (index_q)
						REG_JOYPAD:   r.data = regs[REG_JOY_GATE][0] ? joy : 8'hff;
						REG_TIMER_LO: r.data = timer_q[7:0];
						REG_TIMER_HI: r.data = timer_q[15:8];
						REG_SEC:      r.data = {2'b00, sec_q};
						REG_MIN:      r.data = {2'b00, min_q};
						REG_HOUR:     r.data = {3'b000, hour_q};
						REG_DAY_LO:   r.data = wide[7:0];
						REG_DAY_HI:   r.data = wide[15:8];
						REG_IRQ_STAT: r.data = {r.data[7:2], req_q};
						REG_WPROT: begin
							r.data = {r.data[7:1], wprot_q};
							wprot_q = 1'b0;
						end
						default: ;
					endcase
				end
			end
			OP_WRITE: begin
				if (port == PORT_INDEX) begin
					index_q = wd;
				end else begin
					regs[index_q] = wd;
					case (index_q)
						REG_SEC:  sec_q = wd[5:0];
						REG_MIN:  min_q = wd[5:0];
						REG_HOUR: hour_q = wd[4:0];
						REG_DAY_LO: begin
							wide[7:0] = wd;
							day_q = wide[DAY_BITS-1:0];
						end
						REG_DAY_HI: begin
							wide = {16'h0000, wd, wide[7:0]};
							day_q = wide[DAY_BITS-1:0];
						end
						REG_ALM_SEC:  alm_sec = wd[5:0];
						REG_ALM_MIN:  alm_min = wd[5:0];
						REG_ALM_HOUR: alm_hour = wd[4:0];
						REG_ALM_DAY:  alm_day = wd[4:0];
						REG_IRQ_EN:   en_q = wd[1:0];
						REG_IRQ_STAT: if (wd[1]) req_q = 2'b00;
						default: ;
					endcase
				end
			end
			OP_TICK: begin
				// counters wider than the fields so out-of-range values still carry
				s = int'(sec_q) + 1;
				if (s >= 60) begin
					s = 0;
					m = int'(min_q) + 1;
					if (m >= 60) begin
						m = 0;
						h = int'(hour_q) + 1;
						if (h >= 24) begin
							h = 0;
							day_q = day_q + 1'b1;
						end
						hour_q = h[4:0];
					end
					min_q = m[5:0];
				end
				sec_q = s[5:0];
				req_q[0] = 1'b1;
				if (sec_q == alm_sec && min_q == alm_min && hour_q == alm_hour &&
						day_q[4:0] == alm_day) begin
					req_q[1] = 1'b1;
					alarm_matches++;
				end
			end
			default: ;
		endcase
		r.irq = |(req_q & en_q);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			index_q = 8'h00;
			for (int i = 0; i < 256; i++)
				regs[i] = 8'h00;
			timer_q = TIMER_RESET;
			sec_q = '0;
			min_q = '0;
			hour_q = '0;
			day_q = '0;
			alm_sec = '0;
			alm_min = '0;
			alm_hour = '0;
			alm_day = '0;
			en_q = '0;
			req_q = '0;
			wprot_q = 1'b1;
			errors = 0;
			compared = 0;
			alarm_matches = 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(apply_item(opcode, port_select, write_data,
					joypad));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result item: expected none, got data %02h irq %0b",
						$time, read_data, irq);
				end else begin
					oldest = expected_results.pop_front();
					compared++;
					if (read_data !== oldest.data) begin
						errors++;
						$display("%0t: read_data mismatch: expected %02h, got %02h",
							$time, oldest.data, read_data);
					end
					if (irq !== oldest.irq) begin
						errors++;
						$display("%0t: irq mismatch: expected %0b, got %0b",
							$time, oldest.irq, irq);
					end
				end
			end
		end
		fail_count <= errors;
		outstanding <= expected_results.size();
		checked_count <= compared;
		alarm_hits <= alarm_matches;
	end

endmodule

`default_nettype wire

// ----- test/indexed_register_block_with_rtc_core_tb.sv -----
// ----------------------------------------------------------------------------
// indexed_register_block_with_rtc_core_tb
// Drives bus reads, writes and clock ticks into the register block; a
// separate checker predicts every result item and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_register_block_with_rtc_core_tb;

	import irbrtc_pkg::*;

	localparam int ITEM_TARGET = 1950;
	localparam int QUIET_TAIL  = 200;
	localparam int CYCLE_LIMIT = 400000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] opcode = OP_READ;
	logic       port_select = PORT_INDEX;
	logic [7:0] write_data = 8'h00;
	logic [7:0] joypad = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] read_data;
	logic       irq;

	int fail_count;
	int outstanding;
	int checked_count;
	int alarm_hits;

	// Stimulus bookkeeping and idling knobs.
	int n_sent = 0;
	int n_reads = 0;
	int n_writes = 0;
	int n_ticks = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int cycles = 0;
	bit quiet = 1'b0;

	indexed_register_block_with_rtc_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.port_select(port_select),
		.write_data(write_data),
		.joypad(joypad),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.irq(irq)
	);

	irbrtc_bus_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.port_select(port_select),
		.write_data(write_data),
		.joypad(joypad),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.irq(irq),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.checked_count(checked_count),
		.alarm_hits(alarm_hits)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run; the normal run needs only a small fraction of this.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: drop out_ready in bursts, never in the quiet tail.
	// hold_left counts the remaining low cycles after this one.
	always @(posedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			out_ready <= 1'b0;
			hold_left <= $urandom_range(1, 6) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Present one item and hold it until the block accepts it, then maybe
	// idle the input side for a short burst. Called right after a rising edge.
	task automatic put_item(input opcode_t op, input logic port, input logic [7:0] data,
			input logic [7:0] joy);
		in_valid <= 1'b1;
		opcode <= op;
		port_select <= port;
		write_data <= data;
		joypad <= joy;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
		case (op)
			OP_READ:  n_reads++;
			OP_WRITE: n_writes++;
			default:  n_ticks++;
		endcase
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	task automatic reg_write(input logic [7:0] idx, input logic [7:0] data);
		put_item(OP_WRITE, PORT_INDEX, idx, 8'($urandom));
		put_item(OP_WRITE, PORT_DATA, data, 8'($urandom));
	endtask

	task automatic reg_read(input logic [7:0] idx, input logic [7:0] joy);
		put_item(OP_WRITE, PORT_INDEX, idx, 8'($urandom));
		put_item(OP_READ, PORT_DATA, 8'($urandom), joy);
	endtask

	task automatic tick();
		put_item(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
	endtask

	// Most random index writes land on the decoded registers.
	function automatic logic [7:0] pick_index();
		case ($urandom_range(0, 15))
			0:  return REG_JOY_GATE;
			1:  return REG_JOYPAD;
			2:  return REG_TIMER_LO;
			3:  return REG_TIMER_HI;
			4:  return REG_SEC;
			5:  return REG_MIN;
			6:  return REG_HOUR;
			7:  return REG_DAY_LO;
			8:  return REG_DAY_HI;
			9:  return REG_ALM_SEC;
			10: return REG_ALM_MIN;
			11: return REG_ALM_HOUR;
			12: return REG_ALM_DAY;
			13: return REG_IRQ_EN;
			14: return REG_IRQ_STAT;
			default: return REG_WPROT;
		endcase
	endfunction

	// Set a random time, arm the alarm for the next second (now and then one
	// field off so it misses), and tick. A quarter of the runs start at
	// 23:59:59 so the tick carries into the day and the alarm compares the
	// new day modulo 32.
	task automatic alarm_run();
		logic [5:0]          s;
		logic [5:0]          m;
		logic [4:0]          h;
		logic [DAY_BITS-1:0] d;
		logic [DAY_BITS-1:0] d_next;
		logic [5:0]          a_s;
		logic [5:0]          a_m;
		logic [4:0]          a_h;
		logic [4:0]          a_d;
		if ($urandom_range(0, 3) == 0) begin
			s = 6'd59;
			m = 6'd59;
			h = 5'd23;
		end else begin
			s = 6'($urandom_range(0, 58));
			m = 6'($urandom_range(0, 59));
			h = 5'($urandom_range(0, 23));
		end
		d = DAY_BITS'($urandom);
		d_next = d + 1'b1;
		if (s == 6'd59) begin
			a_s = 6'd0;
			a_m = 6'd0;
			a_h = 5'd0;
			a_d = d_next[4:0];
		end else begin
			a_s = s + 1'b1;
			a_m = m;
			a_h = h;
			a_d = d[4:0];
		end
		if ($urandom_range(0, 4) == 0)
			a_d = a_d ^ 5'h01;
		reg_write(REG_SEC, {2'b00, s});
		reg_write(REG_MIN, {2'b00, m});
		reg_write(REG_HOUR, {3'b000, h});
		reg_write(REG_DAY_LO, d[7:0]);
		reg_write(REG_DAY_HI, 8'(d >> 8));
		reg_write(REG_ALM_SEC, {2'b00, a_s});
		reg_write(REG_ALM_MIN, {2'b00, a_m});
		reg_write(REG_ALM_HOUR, {3'b000, a_h});
		reg_write(REG_ALM_DAY, {3'b000, a_d});
		reg_write(REG_IRQ_EN, 8'($urandom_range(0, 3)));
		tick();
		if ($urandom_range(0, 1) == 0)
			reg_read(REG_IRQ_STAT, 8'($urandom));
	endtask

	initial begin
		int sel;
		int phase;
		int last_phase;
		last_phase = -1;

		// Hold reset, then release it on a rising edge.
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Index port readback, and a never-written entry reads zero.
		put_item(OP_READ, PORT_INDEX, 8'hff, 8'hff);
		put_item(OP_READ, PORT_DATA, 8'h00, 8'h00);
		// Write protect reads set once after reset, then clear.
		put_item(OP_WRITE, PORT_INDEX, REG_WPROT, 8'h00);
		put_item(OP_READ, PORT_DATA, 8'h00, 8'h00);
		put_item(OP_READ, PORT_DATA, 8'h00, 8'h00);
		// Stand-in timer high byte after several read advances.
		reg_read(REG_TIMER_HI, 8'h00);
		// Joypad passes through once the gate bit is set.
		reg_write(REG_JOY_GATE, 8'hff);
		reg_read(REG_JOYPAD, 8'h00);
		// Out-of-range time at full scale, day at 0xfff: one tick wraps every
		// counter to zero, which also matches the all-zero alarm.
		reg_write(REG_DAY_HI, 8'hff);
		reg_write(REG_DAY_LO, 8'hff);
		reg_write(REG_HOUR, 8'hff);
		reg_write(REG_MIN, 8'hff);
		reg_write(REG_SEC, 8'hff);
		put_item(OP_TICK, PORT_INDEX, 8'h00, 8'hff);
		// Enable both requests, read status, then clear with bit 1.
		reg_write(REG_IRQ_EN, 8'hff);
		reg_read(REG_IRQ_STAT, 8'hff);
		put_item(OP_WRITE, PORT_DATA, 8'h02, 8'hff);

		// Random part.
		while (n_sent < ITEM_TARGET) begin
			// Re-pick the idling rates every 150 items, so some stretches
			// run with no idling at all.
			phase = n_sent / 150;
			if (phase != last_phase) begin
				last_phase = phase;
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 10;
					default: gap_pct = 35;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 35;
				endcase
			end
			if (n_sent >= ITEM_TARGET - QUIET_TAIL)
				quiet = 1'b1;

			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				if ($urandom_range(0, 9) < 7)
					put_item(OP_WRITE, PORT_INDEX, pick_index(), 8'($urandom));
				else
					put_item(OP_WRITE, PORT_INDEX, 8'($urandom), 8'($urandom));
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 1) == 0)
						put_item(OP_READ, PORT_DATA, 8'($urandom), 8'($urandom));
					else
						put_item(OP_WRITE, PORT_DATA, 8'($urandom), 8'($urandom));
				end
			end else if (sel < 55) begin
				repeat ($urandom_range(1, 3))
					tick();
			end else if (sel < 65) begin
				alarm_run();
			end else if (sel < 75) begin
				put_item(opcode_t'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
					8'($urandom), 8'($urandom));
			end else if (sel < 85) begin
				put_item(OP_READ, PORT_INDEX, 8'($urandom), 8'($urandom));
			end else begin
				reg_write(REG_IRQ_EN, 8'($urandom));
				reg_read(REG_IRQ_STAT, 8'($urandom));
				if ($urandom_range(0, 1) == 0)
					put_item(OP_WRITE, PORT_DATA, 8'($urandom), 8'($urandom));
			end
		end

		// Drain: the checker's outstanding count is registered, so let it update first.
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);

		$display("Ran %0d items (%0d reads, %0d writes, %0d ticks), %0d results compared.",
			n_sent, n_reads, n_writes, n_ticks, checked_count);
		$display("Alarm fired %0d times; idling on both sides came and went by phase.",
			alarm_hits);
		if (fail_count == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
